// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL; only the table core includes them.
// Depends on nothing; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/bdmt_pkg.sv
// Package for the descriptor medoid table: sizes, status codes, popcount.
// No dependencies.
`default_nettype none
package bdmt_pkg;
  localparam int MaxEntriesDefault = 32;
  localparam int DescBits = 256;
  localparam int KeyW  = 31;
  localparam int WordW = 64;
  localparam int DistW = 9;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_REMOVED = 2'd1,
    ST_IGNORED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  function automatic logic [6:0] ones64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) n = n + {6'd0, v[i]};
    return n;
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/bdmt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module bdmt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/bdmt_hamming.sv
// Hamming distance of two 256-bit descriptors from registered 64-bit popcounts.
// Depends on bdmt_pkg.
`default_nettype none
module bdmt_hamming (
  input  wire logic                  clk,
  input  wire logic [255:0]          a,
  input  wire logic [255:0]          b,
  output logic      [bdmt_pkg::DistW-1:0] ham_dist
);
  import bdmt_pkg::*;
  logic [255:0] x;
  logic [6:0] p0, p1, p2, p3;
  assign x = a ^ b;
  always_ff @(posedge clk) begin
    p0 <= ones64(x[63:0]);
    p1 <= ones64(x[127:64]);
    p2 <= ones64(x[191:128]);
    p3 <= ones64(x[255:192]);
  end
  assign ham_dist = {2'b0, p0} + {2'b0, p1} + {2'b0, p2} + {2'b0, p3};
endmodule
`default_nettype wire

// File: hw/rtl/binary_descriptor_medoid_table_core.sv
// Descriptor medoid table core: one item at a time through one read address shared by its RAMs.
// Per item: key search, sum update sweep, medoid sweep, then fetch and output; a remove
// first reads back the removed descriptor before its sum update, and an ignored or full
// item goes from the key search straight to fetch and output; an output stall holds the
// core in S_OUT, and no new item is taken until the result is transferred.
// Reset (rst, synchronous) clears valid bits, count and medoid; RAMs need no clear.
`default_nettype none
`include "assert_macros.svh"
module binary_descriptor_medoid_table_core #(
  parameter int MAX_ENTRIES = bdmt_pkg::MaxEntriesDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // tdata: keyframe_id[30:0], desc_word0..3 [286:31], zero fill to 288
  input  wire logic [287:0] s_tdata,
  // tuser: command
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // tdata: status[1:0], rep_valid[2], rep_keyframe_id[33:3],
  // rep_word0..3[289:34], entry_count[295:290]
  output logic      [295:0] m_tdata
);
  import bdmt_pkg::*;
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = DistW + AW;
  // idx marks for the read-back of a removed descriptor
  localparam logic [CW:0] FetchGone = (CW+1)'(MAX_ENTRIES + 1);
  localparam logic [CW:0] FetchWait = (CW+1)'(MAX_ENTRIES + 2);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_FIND = 6'b000010, S_UPD = 6'b000100,
    S_MED  = 6'b001000, S_OUT  = 6'b010000, S_FETCH = 6'b100000
  } state_t;
  state_t state;

  logic [MAX_ENTRIES-1:0] used;
  logic [CW-1:0] count;
  logic [AW-1:0] rep;
  logic rep_present;
  logic cmd;
  logic [KeyW-1:0] key;
  logic [255:0] desc;          // new descriptor, or the removed one
  logic [CW:0] idx;            // issue counter
  logic hit;
  logic [AW-1:0] hit_slot, free_slot;
  logic free_found;
  logic [SW-1:0] own;
  logic [SW-1:0] best_sum;
  logic [KeyW-1:0] best_key;
  logic best_found;
  logic [1:0] status;

  // RAM ports
  logic k_we, d_we, s_we;
  logic [AW-1:0] waddr, raddr, saddr;
  logic [KeyW-1:0] k_rd;
  logic [255:0] d_rd, d_wdata;
  logic [SW-1:0] s_rd, s_wdata;
  logic [DistW-1:0] ham_dist;

  bdmt_ram #(.Width(KeyW), .Depth(MAX_ENTRIES)) u_key (
    .clk, .we(k_we), .waddr, .wdata(key), .raddr, .rdata(k_rd));
  bdmt_ram #(.Width(DescBits), .Depth(MAX_ENTRIES)) u_desc (
    .clk, .we(d_we), .waddr, .wdata(d_wdata), .raddr, .rdata(d_rd));
  bdmt_ram #(.Width(SW), .Depth(MAX_ENTRIES)) u_sum (
    .clk, .we(s_we), .waddr(saddr), .wdata(s_wdata), .raddr, .rdata(s_rd));
  bdmt_hamming u_ham (.clk, .a(desc), .b(d_rd), .ham_dist);

  // Read issue stays ahead; the pipeline stages: RAM read, popcount register.
  logic [AW-1:0] r1, r2;
  logic v1, v2;
  logic issuing;
  assign issuing = (state == S_FIND || state == S_UPD || state == S_MED)
                   && (idx < (CW+1)'(MAX_ENTRIES));
  assign raddr = (state == S_FETCH) ? rep : idx[AW-1:0];
  assign s_tready = (state == S_IDLE);

  // Sum update in S_UPD on the stage-2 slot; slot sums are read in stage 1
  // and held, so each slot's read/modify/write never overlaps another.
  logic [SW-1:0] s_hold;
  logic [SW-1:0] dext;
  assign dext = SW'(ham_dist);
  always_comb begin
    s_we = 1'b0; saddr = r2; s_wdata = s_hold;
    k_we = 1'b0; d_we = 1'b0; waddr = free_slot; d_wdata = desc;
    if (state == S_UPD && v2 && used[r2]) begin
      s_we = 1'b1;
      if (cmd == CMD_ADD) s_wdata = s_hold + dext;
      else s_wdata = (s_hold >= dext) ? s_hold - dext : '0;
    end
    if (state == S_UPD && idx == (CW+1)'(MAX_ENTRIES) && !v1 && !v2 && cmd == CMD_ADD) begin
      k_we = 1'b1; d_we = 1'b1; s_we = 1'b1; saddr = free_slot; s_wdata = own;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; used <= '0; count <= '0; rep <= '0; rep_present <= 1'b0;
      m_tvalid <= 1'b0; v1 <= 1'b0; v2 <= 1'b0;
    end else begin
      v1 <= issuing;
      v2 <= v1 && (state == S_UPD);
      r1 <= idx[AW-1:0];
      r2 <= r1;
      s_hold <= s_rd;
      if (issuing) idx <= idx + 1'b1;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd <= s_tuser; key <= s_tdata[KeyW-1:0]; desc <= s_tdata[KeyW+255:KeyW];
            idx <= '0; hit <= 1'b0; free_found <= 1'b0; own <= '0;
            state <= S_FIND;
          end
        end
        S_FIND: begin
          if (v1) begin
            if (used[r1] && k_rd == key) begin hit <= 1'b1; hit_slot <= r1; end
            if (!used[r1] && !free_found) begin free_found <= 1'b1; free_slot <= r1; end
          end
          if (!issuing && !v1) begin
            if (cmd == CMD_ADD && hit) begin
              status <= ST_IGNORED; idx <= '0; state <= S_FETCH;
            end else if (cmd == CMD_ADD && !free_found) begin
              status <= ST_FULL; idx <= '0; state <= S_FETCH;
            end else if (cmd == CMD_REMOVE && !hit) begin
              status <= ST_IGNORED; idx <= '0; state <= S_FETCH;
            end else if (cmd == CMD_REMOVE) begin
              // read back the removed descriptor through rep; the medoid sweep
              // sets rep again afterwards
              used[hit_slot] <= 1'b0; rep <= hit_slot; status <= ST_REMOVED;
              idx <= FetchGone; state <= S_FETCH;
            end else begin
              status <= ST_ADDED; idx <= '0; state <= S_UPD;
            end
          end
        end
        S_OUT: begin
          // RAM data from the fetch cycle is captured on the first cycle here
          if (!m_tvalid) begin
            m_tvalid <= 1'b1;
            m_tdata <= {count, (rep_present ? d_rd : 256'd0),
                        (rep_present ? k_rd : {KeyW{1'b0}}), rep_present, status};
          end else if (m_tready) begin
            m_tvalid <= 1'b0; state <= S_IDLE;
          end
        end
        S_UPD: begin
          if (v2 && used[r2] && cmd == CMD_ADD) own <= own + dext;
          if (!issuing && !v1 && !v2) begin
            if (cmd == CMD_ADD) begin
              used[free_slot] <= 1'b1; count <= count + 1'b1;
            end else count <= count - 1'b1;
            idx <= '0; best_found <= 1'b0; state <= S_MED;
          end
        end
        S_MED: begin
          if (v1 && used[r1]) begin
            if (!best_found || s_rd < best_sum || (s_rd == best_sum && k_rd < best_key)) begin
              best_found <= 1'b1; best_sum <= s_rd; best_key <= k_rd; rep <= r1;
            end
          end
          if (!issuing && !v1) begin
            rep_present <= best_found;
            if (!best_found) rep <= '0;
            idx <= '0; state <= S_FETCH;
          end
        end
        S_FETCH: begin
          // rep sits on the read address; its data is ready in the next cycle
          if (idx == FetchGone) idx <= FetchWait;
          else if (idx == FetchWait) begin
            desc <= d_rd; idx <= '0; state <= S_UPD; // removed descriptor loaded
          end else state <= S_OUT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst, s_tready, !m_tvalid)
  `ASSERT_IMPL(a_count_max, clk, rst, 1'b1, count <= CW'(MAX_ENTRIES))
  `ASSERT_NEXT(a_present, clk, rst, m_tvalid && m_tdata[2], count != '0)
endmodule
`default_nettype wire

// File: verif/binary_descriptor_medoid_table_core_tb.sv
// Testbench for binary_descriptor_medoid_table_core: directed table, then random add/remove
// traffic, each result checked against a behavioural medoid-table predictor.
// Depends on bdmt_pkg and the core RTL only.
`timescale 1ns / 1ps
`default_nettype none
module binary_descriptor_medoid_table_core_tb;
  import bdmt_pkg::*;

  localparam int NSlots = 32;
  localparam int LimitCycles = 1500000;

  typedef struct {
    logic           cmd;
    logic [30:0]    key;
    logic [255:0]   desc;
  } cmd_item_t;

  typedef struct packed {
    status_t        status;
    logic           rep_valid;
    logic [30:0]    rep_key;
    logic [255:0]   rep_desc;
    logic [5:0]     count;
  } table_view_t;

  // directed row: item plus optional typed-in expectation
  typedef struct {
    cmd_item_t      item;
    logic           fixed;
    table_view_t    want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [287:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [295:0] m_tdata;

  binary_descriptor_medoid_table_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor's own copy of the table
  logic         tbl_used [NSlots];
  logic [30:0]  tbl_key  [NSlots];
  logic [255:0] tbl_desc [NSlots];
  int unsigned  tbl_sum  [NSlots];
  int           tbl_count;

  table_view_t  pending_views[$];
  int           fail_count = 0;
  int           result_count = 0;
  int           cycle_count = 0;
  bit           hold_off = 1'b0;
  bit           sending_done = 1'b0;
  int           n_added = 0, n_removed = 0, n_ignored = 0, n_full = 0;

  function automatic int unsigned desc_distance(logic [255:0] a, logic [255:0] b);
    return $countones(a ^ b);
  endfunction

  function automatic table_view_t apply_command(cmd_item_t it);
    table_view_t v;
    int at, s, best;
    int unsigned d, own;
    at = -1;
    for (int i = 0; i < NSlots; i++)
      if (tbl_used[i] && tbl_key[i] == it.key) at = i;
    if (it.cmd == CMD_ADD) begin
      if (at >= 0) v.status = ST_IGNORED;
      else if (tbl_count >= NSlots) v.status = ST_FULL;
      else begin
        s = 0;
        while (tbl_used[s]) s++;
        own = 0;
        for (int i = 0; i < NSlots; i++)
          if (tbl_used[i]) begin
            d = desc_distance(it.desc, tbl_desc[i]);
            tbl_sum[i] += d;
            own += d;
          end
        tbl_desc[s] = it.desc;
        tbl_key[s] = it.key;
        tbl_sum[s] = own;
        tbl_used[s] = 1'b1;
        tbl_count++;
        v.status = ST_ADDED;
      end
    end else begin
      if (at < 0) v.status = ST_IGNORED;
      else begin
        tbl_used[at] = 1'b0;
        for (int i = 0; i < NSlots; i++)
          if (tbl_used[i]) begin
            d = desc_distance(tbl_desc[at], tbl_desc[i]);
            tbl_sum[i] = (tbl_sum[i] >= d) ? tbl_sum[i] - d : 0;
          end
        tbl_count--;
        v.status = ST_REMOVED;
      end
    end
    // least sum wins, lowest key on a tie
    best = -1;
    for (int i = 0; i < NSlots; i++)
      if (tbl_used[i] && (best < 0 || tbl_sum[i] < tbl_sum[best] ||
          (tbl_sum[i] == tbl_sum[best] && tbl_key[i] < tbl_key[best])))
        best = i;
    v.rep_valid = (best >= 0);
    v.rep_key   = (best >= 0) ? tbl_key[best] : '0;
    v.rep_desc  = (best >= 0) ? tbl_desc[best] : '0;
    v.count     = tbl_count[5:0];
    return v;
  endfunction

  // one transfer on the slave side; the prediction is queued at acceptance
  task automatic send_command(cmd_item_t it, logic fixed, table_view_t want);
    table_view_t v;
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.cmd;
    s_tdata  <= {1'b0, it.desc, it.key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    v = apply_command(it);
    if (fixed && v !== want) begin
      $error("typed-in row for key %0h: expected %p, predictor gives %p", it.key, want, v);
      fail_count++;
    end
    pending_views.push_back(fixed ? want : v);
  endtask

  function automatic logic [255:0] rand_desc();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // near-duplicate descriptors give ties and close medoid choices
  function automatic logic [255:0] near_desc(logic [255:0] base);
    logic [255:0] r;
    r = base;
    for (int k = $urandom_range(0, 6); k > 0; k--) r[$urandom_range(0, 255)] ^= 1'b1;
    return r;
  endfunction

  function automatic cmd_item_t mk(logic c, logic [30:0] k, logic [255:0] d);
    cmd_item_t it;
    it.cmd = c; it.key = k; it.desc = d;
    return it;
  endfunction

  function automatic table_view_t mk_view(status_t st, logic rv, logic [30:0] k,
                                          logic [255:0] d, logic [5:0] n);
    table_view_t v;
    v.status = st; v.rep_valid = rv; v.rep_key = k; v.rep_desc = d; v.count = n;
    return v;
  endfunction

  // stimulus
  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    logic [30:0] keys[$];
    logic [255:0] base;
    cmd_item_t it;
    int pick, mode;
    table_view_t none;
    none = mk_view(ST_ADDED, 1'b0, '0, '0, '0);

    for (int i = 0; i < NSlots; i++) begin
      tbl_used[i] = 1'b0; tbl_key[i] = '0; tbl_desc[i] = '0; tbl_sum[i] = 0;
    end
    tbl_count = 0;

    // directed table
    r.fixed = 1'b1;
    r.item = mk(CMD_REMOVE, 31'd5, '0);            // remove on empty table
    r.want = mk_view(ST_IGNORED, 1'b0, '0, '0, 6'd0);   rows.push_back(r);
    r.item = mk(CMD_ADD, 31'h7FFFFFFF, '1);          // all ones, largest key
    r.want = mk_view(ST_ADDED, 1'b1, 31'h7FFFFFFF, '1, 6'd1); rows.push_back(r);
    r.item = mk(CMD_ADD, 31'h7FFFFFFF, '0);          // duplicate add
    r.want = mk_view(ST_IGNORED, 1'b1, 31'h7FFFFFFF, '1, 6'd1); rows.push_back(r);
    r.item = mk(CMD_ADD, 31'd0, '0);                 // equal sums: key 0 wins
    r.want = mk_view(ST_ADDED, 1'b1, 31'd0, '0, 6'd2);  rows.push_back(r);
    r.fixed = 1'b0; r.want = none;
    r.item = mk(CMD_ADD, 31'd1, {128'd0, {128{1'b1}}});         rows.push_back(r);
    r.item = mk(CMD_REMOVE, 31'd0, '1);              // desc ignored on remove
    rows.push_back(r);
    r.item = mk(CMD_REMOVE, 31'd99, '0);             rows.push_back(r);
    r.item = mk(CMD_REMOVE, 31'd1, '0);              rows.push_back(r);
    r.fixed = 1'b1;
    r.item = mk(CMD_REMOVE, 31'h7FFFFFFF, '0);       // back to empty
    r.want = mk_view(ST_REMOVED, 1'b0, '0, '0, 6'd0);   rows.push_back(r);
    r.fixed = 1'b0; r.want = none;
    // fill to capacity, then one add too many
    for (int i = 0; i < NSlots; i++) begin
      r.item = mk(CMD_ADD, 31'(100 + i), rand_desc()); rows.push_back(r);
    end
    r.item = mk(CMD_ADD, 31'd7, '1); rows.push_back(r);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_command(rows[i].item, rows[i].fixed, rows[i].want);

    // long hold-off on the output while items keep coming
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++)
      send_command(mk(CMD_REMOVE, 31'(100 + 2 * i), '0), 1'b0, none);
    hold_off = 1'b0;

    // random part: mostly valid adds/removes on a small key pool
    base = rand_desc();
    for (int i = 0; i < 40; i++) keys.push_back(31'(100 + i));
    for (int n = 0; n < 500; n++) begin
      mode = $urandom_range(0, 99);
      pick = $urandom_range(0, keys.size() - 1);
      if (mode < 5)
        it = mk(1'($urandom_range(0, 1)), 31'($urandom), rand_desc());
      else if (mode < 50)
        it = mk(CMD_ADD, keys[pick], ($urandom_range(0, 1)) ? near_desc(base) : rand_desc());
      else
        it = mk(CMD_REMOVE, keys[pick], rand_desc());
      if (mode >= 97) base = rand_desc();
      send_command(it, 1'b0, none);
    end
    s_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // result side: random stalls plus the hold-off stretch
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap) @(posedge clk);
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      m_tready <= 1'b0;
    end
  end

  // checker: sample at the edge where the transfer happens
  always @(posedge clk) begin
    table_view_t w;
    if (!rst && m_tvalid && m_tready) begin
      result_count++;
      if (pending_views.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        w = pending_views.pop_front();
        case (w.status)
          ST_ADDED:   n_added++;
          ST_REMOVED: n_removed++;
          ST_IGNORED: n_ignored++;
          default:    n_full++;
        endcase
        if (m_tdata[1:0] !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, m_tdata[1:0]); fail_count++;
        end
        if (m_tdata[2] !== w.rep_valid) begin
          $error("rep_valid: expected %0d, got %0d", w.rep_valid, m_tdata[2]); fail_count++;
        end
        if (m_tdata[33:3] !== w.rep_key) begin
          $error("rep_keyframe_id: expected %0h, got %0h", w.rep_key, m_tdata[33:3]);
          fail_count++;
        end
        for (int k = 0; k < 4; k++)
          if (m_tdata[34 + 64 * k +: 64] !== w.rep_desc[64 * k +: 64]) begin
            $error("rep_word%0d: expected %h, got %h", k, w.rep_desc[64 * k +: 64],
                   m_tdata[34 + 64 * k +: 64]);
            fail_count++;
          end
        if (m_tdata[295:290] !== w.count) begin
          $error("entry_count: expected %0d, got %0d", w.count, m_tdata[295:290]);
          fail_count++;
        end
      end
    end
  end

  // end of run and timeout
  initial begin
    while (!(sending_done && pending_views.size() == 0) && cycle_count < LimitCycles)
      @(posedge clk);
    repeat (120) @(posedge clk);
    if (cycle_count >= LimitCycles) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
    end else begin
      $display("checked %0d results: %0d adds, %0d removes, %0d ignored, %0d table full",
               result_count, n_added, n_removed, n_ignored, n_full);
      if (fail_count == 0 && pending_views.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;
endmodule
`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bdmt_pkg.sv
hw/rtl/bdmt_ram.sv
hw/rtl/bdmt_hamming.sv
hw/rtl/binary_descriptor_medoid_table_core.sv
verif/binary_descriptor_medoid_table_core_tb.sv
